/* design/dopq_pkg.sv */
// Shared types and constants for the dual order preferential queue.
// No dependencies; used by every other file of the block.
package dopq_pkg;

	localparam int unsigned CAPACITY  = 16;
	localparam int unsigned ID_WIDTH  = 16;
	localparam int unsigned AGE_WIDTH = 8;
	localparam int unsigned IDX_W     = $clog2(CAPACITY);
	localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);

	localparam logic [2:0] REQ_INSERT   = 3'd0;
	localparam logic [2:0] REQ_REM_PREF = 3'd1;
	localparam logic [2:0] REQ_REM_FIFO = 3'd2;
	localparam logic [2:0] REQ_ABANDON  = 3'd3;
	localparam logic [2:0] REQ_QUERY    = 3'd4;

	typedef struct packed {
		logic [2:0]           req_type;
		logic [ID_WIDTH-1:0]  entry_id;
		logic [AGE_WIDTH-1:0] entry_age;
	} req_t;

	typedef struct packed {
		logic                 ok;
		logic [ID_WIDTH-1:0]  out_id;
		logic [AGE_WIDTH-1:0] out_age;
		logic [CNT_W-1:0]     count;
	} rsp_t;

	typedef struct packed {
		logic [ID_WIDTH-1:0]  id;
		logic [AGE_WIDTH-1:0] age;
	} entry_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] addr;
		entry_t           data;
	} mem_wr_t;

endpackage

/* design/dopq_store.sv */
// Entry store: one write port and one registered read port.
// Depends on dopq_pkg for the entry and write port types.
module dopq_store (
	input  logic                          clk,
	input  dopq_pkg::mem_wr_t             wr,
	input  logic                          rd_en,
	input  logic [dopq_pkg::IDX_W-1:0]    rd_addr,
	output dopq_pkg::entry_t              rd_data
);

	dopq_pkg::entry_t mem [dopq_pkg::CAPACITY];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* design/dual_order_preferential_queue.sv */
// Top level of the dual order preferential queue: sequencer around the entry store.
// Depends on dopq_pkg and dopq_store.
//
//   channel   ports                    transfer
//   request   start, busy, request     start high and busy low at a rising edge
//   result    done, result             done high for one cycle, taken at its end
//
// A request scans all held entries through the store's read port, one a cycle,
// then a removal compacts the entries behind the taken one, one a cycle.
// Reset clears the count and the control registers; store contents need no clearing pass.
// The receiver cannot stall; busy drops in the cycle done is shown.
module dual_order_preferential_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  dopq_pkg::req_t       request,
	output logic                 done,
	output dopq_pkg::rsp_t       result
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_EVAL  = 4'b0100,
		ST_SHIFT = 4'b1000
	} state_t;

	state_t                       state_q;
	dopq_pkg::req_t               req_q;
	dopq_pkg::entry_t             rec_q;
	dopq_pkg::rsp_t               rsp_q;
	logic [dopq_pkg::CNT_W-1:0]   cnt_q;
	logic [dopq_pkg::CNT_W-1:0]   rd_idx_q;
	logic [dopq_pkg::IDX_W-1:0]   pos_q;
	logic [dopq_pkg::IDX_W-1:0]   idx_s1;
	logic                         valid_s1;
	logic                         found_q;
	logic                         done_q;

	logic                         rd_en;
	logic                         insert_ok;
	dopq_pkg::entry_t             rd_data;
	dopq_pkg::mem_wr_t            mem_wr;

	assign rd_en = ((state_q == ST_SCAN) || (state_q == ST_SHIFT)) && (rd_idx_q < cnt_q);
	assign insert_ok = !found_q && (cnt_q < dopq_pkg::CNT_W'(dopq_pkg::CAPACITY));

	always_comb begin
		mem_wr = '0;
		if ((state_q == ST_EVAL) && (req_q.req_type == dopq_pkg::REQ_INSERT) && insert_ok) begin
			mem_wr.we       = 1'b1;
			mem_wr.addr     = cnt_q[dopq_pkg::IDX_W-1:0];
			mem_wr.data.id  = req_q.entry_id;
			mem_wr.data.age = req_q.entry_age;
		end else if ((state_q == ST_SHIFT) && valid_s1) begin
			mem_wr.we   = 1'b1;
			mem_wr.addr = idx_s1 - dopq_pkg::IDX_W'(1);
			mem_wr.data = rd_data;
		end
	end

	dopq_store u_store (
		.clk     (clk),
		.wr      (mem_wr),
		.rd_en   (rd_en),
		.rd_addr (rd_idx_q[dopq_pkg::IDX_W-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			req_q    <= '0;
			rec_q    <= '0;
			rsp_q    <= '0;
			cnt_q    <= '0;
			rd_idx_q <= '0;
			pos_q    <= '0;
			idx_s1   <= '0;
			valid_s1 <= 1'b0;
			found_q  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q   <= 1'b0;
			valid_s1 <= rd_en;
			idx_s1   <= rd_idx_q[dopq_pkg::IDX_W-1:0];
			if (rd_en) begin
				rd_idx_q <= rd_idx_q + dopq_pkg::CNT_W'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						req_q    <= request;
						found_q  <= 1'b0;
						rd_idx_q <= '0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (valid_s1) begin
						case (req_q.req_type)
							dopq_pkg::REQ_INSERT, dopq_pkg::REQ_ABANDON,
							dopq_pkg::REQ_QUERY: begin
								if (!found_q && (rd_data.id == req_q.entry_id)) begin
									found_q <= 1'b1;
									pos_q   <= idx_s1;
									rec_q   <= rd_data;
								end
							end
							dopq_pkg::REQ_REM_FIFO: begin
								if (!found_q) begin
									found_q <= 1'b1;
									pos_q   <= idx_s1;
									rec_q   <= rd_data;
								end
							end
							dopq_pkg::REQ_REM_PREF: begin
								if (!found_q || (rd_data.age > rec_q.age)) begin
									found_q <= 1'b1;
									pos_q   <= idx_s1;
									rec_q   <= rd_data;
								end
							end
							default: begin
							end
						endcase
					end
					if (!rd_en && !valid_s1) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					rsp_q.ok      <= 1'b0;
					rsp_q.out_id  <= '0;
					rsp_q.out_age <= '0;
					rsp_q.count   <= cnt_q;
					done_q        <= 1'b1;
					state_q       <= ST_IDLE;
					case (req_q.req_type)
						dopq_pkg::REQ_INSERT: begin
							if (insert_ok) begin
								rsp_q.ok    <= 1'b1;
								rsp_q.count <= cnt_q + dopq_pkg::CNT_W'(1);
								cnt_q       <= cnt_q + dopq_pkg::CNT_W'(1);
							end
						end
						dopq_pkg::REQ_QUERY: begin
							if (found_q) begin
								rsp_q.ok      <= 1'b1;
								rsp_q.out_age <= rec_q.age;
							end
						end
						dopq_pkg::REQ_REM_PREF, dopq_pkg::REQ_REM_FIFO,
						dopq_pkg::REQ_ABANDON: begin
							if (found_q) begin
								done_q   <= 1'b0;
								rd_idx_q <= dopq_pkg::CNT_W'(pos_q) + dopq_pkg::CNT_W'(1);
								state_q  <= ST_SHIFT;
							end
						end
						default: begin
						end
					endcase
				end
				ST_SHIFT: begin
					if (!rd_en && !valid_s1) begin
						rsp_q.ok      <= 1'b1;
						rsp_q.out_id  <= rec_q.id;
						rsp_q.out_age <= rec_q.age;
						rsp_q.count   <= cnt_q - dopq_pkg::CNT_W'(1);
						cnt_q         <= cnt_q - dopq_pkg::CNT_W'(1);
						done_q        <= 1'b1;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = rsp_q;

endmodule

/* design/dopq_checker.sv */
// Port-level checks for the dual order preferential queue, bound to the top level.
// Depends on dopq_pkg and dual_order_preferential_queue.
module dopq_port_checks (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input dopq_pkg::rsp_t    result
);

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after request transfer");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two results for one request");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.count <= dopq_pkg::CNT_W'(dopq_pkg::CAPACITY)))
		else $error("count beyond capacity");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.ok) |-> ((result.out_id == '0) && (result.out_age == '0)))
		else $error("failed request carries entry data");

endmodule

bind dual_order_preferential_queue dopq_port_checks u_dopq_port_checks (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

/* bench/dopq_checker.sv */
// Result checker for the dual order preferential queue: predicts each result from the
// accepted requests and compares it with what the block returns. Depends on dopq_pkg.
module dopq_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  dopq_pkg::req_t   request,
	input  logic             done,
	input  dopq_pkg::rsp_t   result,
	output int unsigned      fail_count,
	output int unsigned      pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import dopq_pkg::*;

	logic [ID_WIDTH-1:0]  held_id  [CAPACITY];
	logic [AGE_WIDTH-1:0] held_age [CAPACITY];
	int                   held_n;
	rsp_t                 owed_replies [$];

	function automatic int locate(logic [ID_WIDTH-1:0] id);
		for (int i = 0; i < held_n; i++) begin
			if (held_id[i] == id)
				return i;
		end
		return -1;
	endfunction

	function automatic rsp_t apply_request(req_t r);
		rsp_t rsp;
		int   take;
		int   pos;
		rsp  = '0;
		take = -1;
		case (r.req_type)
			REQ_INSERT: begin
				if (locate(r.entry_id) < 0 && held_n < CAPACITY) begin
					held_id[held_n]  = r.entry_id;
					held_age[held_n] = r.entry_age;
					held_n++;
					rsp.ok = 1'b1;
				end
			end
			REQ_REM_PREF: begin
				if (held_n > 0) begin
					take = 0;
					for (int i = 1; i < held_n; i++) begin
						if (held_age[i] > held_age[take])
							take = i;
					end
				end
			end
			REQ_REM_FIFO: begin
				if (held_n > 0)
					take = 0;
			end
			REQ_ABANDON: take = locate(r.entry_id);
			REQ_QUERY: begin
				pos = locate(r.entry_id);
				if (pos >= 0) begin
					rsp.ok      = 1'b1;
					rsp.out_age = held_age[pos];
				end
			end
			default: ;
		endcase
		if (take >= 0) begin
			rsp.ok      = 1'b1;
			rsp.out_id  = held_id[take];
			rsp.out_age = held_age[take];
			for (int i = take; i + 1 < held_n; i++) begin
				held_id[i]  = held_id[i + 1];
				held_age[i] = held_age[i + 1];
			end
			held_n--;
		end
		rsp.count = held_n[CNT_W-1:0];
		return rsp;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			held_n = 0;
			fail_count = 0;
			owed_replies.delete();
			pending <= 0;
		end else begin
			if (done) begin
				if (owed_replies.size() == 0) begin
					$error("result with no request outstanding");
					fail_count++;
				end else begin
					want = owed_replies.pop_front();
					if (result.ok !== want.ok) begin
						$error("ok: expected %0d, got %0d", want.ok, result.ok);
						fail_count++;
					end
					if (result.out_id !== want.out_id) begin
						$error("out_id: expected %0h, got %0h", want.out_id, result.out_id);
						fail_count++;
					end
					if (result.out_age !== want.out_age) begin
						$error("out_age: expected %0h, got %0h", want.out_age, result.out_age);
						fail_count++;
					end
					if (result.count !== want.count) begin
						$error("count: expected %0d, got %0d", want.count, result.count);
						fail_count++;
					end
				end
			end
			if (start && !busy)
				owed_replies.push_back(apply_request(request));
			pending <= owed_replies.size();
		end
	end

endmodule

/* bench/tb_top.sv */
// Top of the queue testbench: clock, reset, directed and random requests, verdict.
// Depends on dopq_pkg, dual_order_preferential_queue and dopq_checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import dopq_pkg::*;

	localparam int          RANDOM_ITEMS    = 850;
	localparam int          POOL_SIZE       = 24;
	localparam int          DRAIN_CYCLES    = 2 * CAPACITY + 8;
	localparam logic [2:0]  REQ_BOGUS_FIRST = 3'd5;
	localparam logic [2:0]  REQ_BOGUS_LAST  = 3'd7;
	localparam int          BIAS_FILL       = 0;
	localparam int          BIAS_DRAIN      = 1;

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        start   = 1'b0;
	req_t        request = '0;
	logic        busy;
	logic        done;
	rsp_t        result;
	int unsigned fail_count;
	int unsigned pending;

	logic [ID_WIDTH-1:0] id_pool [POOL_SIZE];

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	dual_order_preferential_queue DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	dopq_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.request    (request),
		.done       (done),
		.result     (result),
		.fail_count (fail_count),
		.pending    (pending)
	);

	task automatic send_request(req_t r, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy);
	endtask

	function automatic req_t random_request(int bias);
		req_t r;
		int   ins_share;
		int   roll;
		ins_share = (bias == BIAS_FILL) ? 60 : (bias == BIAS_DRAIN) ? 20 : 38;
		roll = $urandom_range(0, 9);
		r.entry_id = (roll < 7) ? id_pool[$urandom_range(0, POOL_SIZE - 1)]
		                        : ID_WIDTH'($urandom_range(0, 65535));
		roll = $urandom_range(0, 9);
		case (roll)
			0:       r.entry_age = 8'h00;
			1:       r.entry_age = 8'hFF;
			2, 3, 4: r.entry_age = 8'h7E + AGE_WIDTH'($urandom_range(0, 2));
			default: r.entry_age = AGE_WIDTH'($urandom_range(0, 255));
		endcase
		if ($urandom_range(0, 99) < ins_share) begin
			r.req_type = REQ_INSERT;
		end else begin
			roll = $urandom_range(0, 19);
			if (roll < 6)
				r.req_type = REQ_REM_PREF;
			else if (roll < 10)
				r.req_type = REQ_REM_FIFO;
			else if (roll < 14)
				r.req_type = REQ_ABANDON;
			else if (roll < 19)
				r.req_type = REQ_QUERY;
			else
				r.req_type = 3'($urandom_range(REQ_BOGUS_FIRST, REQ_BOGUS_LAST));
		end
		return r;
	endfunction

	initial begin
		int bias;
		bit idling;
		int gap;
		id_pool[0] = '0;
		id_pool[1] = '1;
		for (int k = 2; k < POOL_SIZE; k++)
			id_pool[k] = ID_WIDTH'($urandom_range(0, 65535));
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// empty store
		send_request('{REQ_REM_PREF, 16'h0000, 8'h00}, 0);
		send_request('{REQ_REM_FIFO, 16'h0000, 8'h00}, 0);
		send_request('{REQ_ABANDON, 16'hFFFF, 8'h00}, 0);
		send_request('{REQ_QUERY, 16'h0000, 8'h00}, 0);
		// extremes and duplicate id
		send_request('{REQ_INSERT, 16'h0000, 8'h00}, 0);
		send_request('{REQ_INSERT, 16'hFFFF, 8'hFF}, 0);
		send_request('{REQ_INSERT, 16'h0000, 8'h55}, 0);
		// fill with tied ages, then overflow
		for (int k = 0; k < CAPACITY - 2; k++)
			send_request('{REQ_INSERT, 16'h1000 + 16'(k), k[0] ? 8'h80 : 8'h20}, 0);
		send_request('{REQ_INSERT, 16'h2000, 8'hFF}, 0);
		send_request('{REQ_QUERY, 16'hFFFF, 8'h00}, 0);
		send_request('{REQ_BOGUS_FIRST, 16'hFFFF, 8'hFF}, 0);
		send_request('{REQ_BOGUS_LAST, 16'h0000, 8'h00}, 0);
		send_request('{REQ_REM_PREF, 16'h0000, 8'h00}, 0);
		send_request('{REQ_REM_PREF, 16'h0000, 8'h00}, 0);
		send_request('{REQ_REM_FIFO, 16'h0000, 8'h00}, 0);
		send_request('{REQ_ABANDON, 16'h1005, 8'h00}, 0);

		bias   = 0;
		idling = 1'b0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 60 == 0)
				bias = $urandom_range(0, 2);
			if (n % 50 == 0)
				idling = (n < RANDOM_ITEMS - 100) && ($urandom_range(0, 3) != 0);
			gap = (idling && $urandom_range(0, 2) == 0) ? $urandom_range(1, 19) : 0;
			send_request(random_request(bias), gap);
		end
		start <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

endmodule
